// ----- rtl/core/adm_filt_pkg.sv -----
// ----------------------------------------------------------------------------
// adm_filt_pkg
// Types and constants shared by the one-axis admittance filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package adm_filt_pkg;

  localparam int IO_WIDTH        = 32;
  localparam int COEF_WIDTH      = 31;
  localparam int STEP_WIDTH      = 17;
  localparam int MUL_B_WIDTH     = 32;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_INV_MASS   = 2'd0,
    REG_DAMP_COEF  = 2'd1,
    REG_STIFF_COEF = 2'd2,
    REG_TIME_STEP  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_UPD
  } state_t;

  typedef enum logic [2:0] {
    MS_FORCE_INV,
    MS_DAMP_VEL,
    MS_STIFF_DISP,
    MS_VEL_DT,
    MS_ACC_DT
  } mul_sel_t;

  typedef enum logic [2:0] {
    AO_NONE,
    AO_LOAD,
    AO_SUB,
    AO_DISP,
    AO_VEL
  } acc_op_t;

  typedef struct packed {
    logic     load_input;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     load_out;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/admittance_filter_one_axis.sv -----
// Each accepted item steps through states MUL0 to MUL4 and then UPD, where the
// result is registered once the output register is free; the single shared
// multiplier is used five times per update, and a new item is taken only in IDLE.
// A finished result may wait in the output register while the next item starts.
// Reset clears the coefficients, velocity and displacement; any coefficient write
// also clears velocity and displacement.
// ----------------------------------------------------------------------------
// admittance_filter_one_axis
// One-axis mass-spring-damper admittance filter with forward Euler integration.
// ----------------------------------------------------------------------------
`default_nettype none

module admittance_filter_one_axis #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic signed [adm_filt_pkg::IO_WIDTH-1:0]  reference,
  input  wire logic signed [adm_filt_pkg::IO_WIDTH-1:0]  ext_force,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic signed [adm_filt_pkg::IO_WIDTH-1:0]       command,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [adm_filt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [adm_filt_pkg::IO_WIDTH-1:0]         cfg_data
);

  adm_filt_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  adm_filt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  adm_filt_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .reference (reference),
    .ext_force (ext_force),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Block accepted an item while an update was in progress.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##7 out_valid)
    else $error("No result was presented after an accepted item.");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || out_ready)
    else $error("Output register was overwritten before its item was taken.");

endmodule

`default_nettype wire

// ----- rtl/core/adm_filt_ctrl.sv -----
// ----------------------------------------------------------------------------
// adm_filt_ctrl
// Sequencer that steps the shared multiplier through one filter update.
// ----------------------------------------------------------------------------
`default_nettype none

module adm_filt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output adm_filt_pkg::dp_cmd_t      cmd
);

  adm_filt_pkg::state_t state;
  adm_filt_pkg::state_t state_next;
  logic                 out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adm_filt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.load_input = 1'b0;
    cmd.mul_sel    = adm_filt_pkg::MS_FORCE_INV;
    cmd.acc_op     = adm_filt_pkg::AO_NONE;
    cmd.load_out   = 1'b0;
    case (state)
      adm_filt_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_input = in_valid;
        if (in_valid) begin
          state_next = adm_filt_pkg::ST_MUL0;
        end
      end
      adm_filt_pkg::ST_MUL0: begin
        cmd.mul_sel = adm_filt_pkg::MS_FORCE_INV;
        state_next  = adm_filt_pkg::ST_MUL1;
      end
      adm_filt_pkg::ST_MUL1: begin
        cmd.mul_sel = adm_filt_pkg::MS_DAMP_VEL;
        cmd.acc_op  = adm_filt_pkg::AO_LOAD;
        state_next  = adm_filt_pkg::ST_MUL2;
      end
      adm_filt_pkg::ST_MUL2: begin
        cmd.mul_sel = adm_filt_pkg::MS_STIFF_DISP;
        cmd.acc_op  = adm_filt_pkg::AO_SUB;
        state_next  = adm_filt_pkg::ST_MUL3;
      end
      adm_filt_pkg::ST_MUL3: begin
        cmd.mul_sel = adm_filt_pkg::MS_VEL_DT;
        cmd.acc_op  = adm_filt_pkg::AO_SUB;
        state_next  = adm_filt_pkg::ST_MUL4;
      end
      adm_filt_pkg::ST_MUL4: begin
        cmd.mul_sel = adm_filt_pkg::MS_ACC_DT;
        cmd.acc_op  = adm_filt_pkg::AO_DISP;
        state_next  = adm_filt_pkg::ST_UPD;
      end
      adm_filt_pkg::ST_UPD: begin
        cmd.mul_sel = adm_filt_pkg::MS_ACC_DT;
        if (!out_valid || out_ready) begin
          cmd.acc_op   = adm_filt_pkg::AO_VEL;
          cmd.load_out = 1'b1;
          state_next   = adm_filt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = adm_filt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/adm_filt_dp.sv -----
// ----------------------------------------------------------------------------
// adm_filt_dp
// Datapath: coefficient registers, filter state, one shared multiplier with
// floor rounding and saturation, and the saturating accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module adm_filt_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire adm_filt_pkg::dp_cmd_t                      cmd,
  input  wire logic signed [adm_filt_pkg::IO_WIDTH-1:0]   reference,
  input  wire logic signed [adm_filt_pkg::IO_WIDTH-1:0]   ext_force,
  input  wire logic                                       cfg_wr,
  input  wire logic [adm_filt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [adm_filt_pkg::IO_WIDTH-1:0]          cfg_data,
  output logic signed [adm_filt_pkg::IO_WIDTH-1:0]        command
);

  localparam int DW = DATA_WIDTH;
  localparam int IW = adm_filt_pkg::IO_WIDTH;
  localparam int BW = adm_filt_pkg::MUL_B_WIDTH;
  localparam int PW = DW + BW;
  localparam int SAT_LO = FRAC_BITS + DW - 1;
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  logic [adm_filt_pkg::COEF_WIDTH-1:0] inv_mass;
  logic [adm_filt_pkg::COEF_WIDTH-1:0] damp_coef;
  logic [adm_filt_pkg::COEF_WIDTH-1:0] stiff_coef;
  logic [adm_filt_pkg::STEP_WIDTH-1:0] time_step;

  logic signed [DW-1:0] velocity;
  logic signed [DW-1:0] displacement;
  logic signed [DW-1:0] acc;
  logic signed [DW-1:0] prod;
  logic signed [DW-1:0] ref_in;
  logic signed [DW-1:0] frc_in;
  logic signed [DW-1:0] ref_x;
  logic signed [DW-1:0] frc_x;

  logic signed [DW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_full;
  logic [PW-1:SAT_LO]   prod_top;
  logic signed [DW-1:0] prod_sat;
  logic signed [DW-1:0] cmd_full;
  logic signed [IW-1:0] cmd_x;

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? DMIN : DMAX;
    end
    return s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? DMIN : DMAX;
    end
    return s[DW-1:0];
  endfunction

  // Inputs wider than the data width are saturated; narrower ones are sign extended.
  generate
    if (DW >= IW) begin : g_in_ext
      assign ref_x = DW'(reference);
      assign frc_x = DW'(ext_force);
    end else begin : g_in_sat
      always_comb begin
        if (&reference[IW-1:DW-1] || ~|reference[IW-1:DW-1]) begin
          ref_x = reference[DW-1:0];
        end else begin
          ref_x = reference[IW-1] ? DMIN : DMAX;
        end
        if (&ext_force[IW-1:DW-1] || ~|ext_force[IW-1:DW-1]) begin
          frc_x = ext_force[DW-1:0];
        end else begin
          frc_x = ext_force[IW-1] ? DMIN : DMAX;
        end
      end
    end
  endgenerate

  always_comb begin
    case (cmd.mul_sel)
      adm_filt_pkg::MS_FORCE_INV: begin
        mul_a = frc_in;
        mul_b = BW'(inv_mass);
      end
      adm_filt_pkg::MS_DAMP_VEL: begin
        mul_a = velocity;
        mul_b = BW'(damp_coef);
      end
      adm_filt_pkg::MS_STIFF_DISP: begin
        mul_a = displacement;
        mul_b = BW'(stiff_coef);
      end
      adm_filt_pkg::MS_VEL_DT: begin
        mul_a = velocity;
        mul_b = BW'(time_step);
      end
      adm_filt_pkg::MS_ACC_DT: begin
        mul_a = acc;
        mul_b = BW'(time_step);
      end
      default: begin
        mul_a = acc;
        mul_b = BW'(time_step);
      end
    endcase
  end

  // The arithmetic shift gives floor rounding; the top bits decide saturation.
  assign prod_full = PW'(mul_a) * PW'(mul_b);
  assign prod_top  = prod_full[PW-1:SAT_LO];

  always_comb begin
    if (&prod_top || ~|prod_top) begin
      prod_sat = prod_full[SAT_LO:FRAC_BITS];
    end else begin
      prod_sat = prod_full[PW-1] ? DMIN : DMAX;
    end
  end

  assign cmd_full = sat_sub(ref_in, displacement);

  generate
    if (DW <= IW) begin : g_out_ext
      assign cmd_x = IW'(cmd_full);
    end else begin : g_out_sat
      always_comb begin
        if (&cmd_full[DW-1:IW-1] || ~|cmd_full[DW-1:IW-1]) begin
          cmd_x = cmd_full[IW-1:0];
        end else begin
          cmd_x = {cmd_full[DW-1], {(IW-1){~cmd_full[DW-1]}}};
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass   <= '0;
      damp_coef  <= '0;
      stiff_coef <= '0;
      time_step  <= '0;
    end else if (cfg_wr) begin
      case (adm_filt_pkg::cfg_reg_t'(cfg_index))
        adm_filt_pkg::REG_INV_MASS:   inv_mass   <= cfg_data[adm_filt_pkg::COEF_WIDTH-1:0];
        adm_filt_pkg::REG_DAMP_COEF:  damp_coef  <= cfg_data[adm_filt_pkg::COEF_WIDTH-1:0];
        adm_filt_pkg::REG_STIFF_COEF: stiff_coef <= cfg_data[adm_filt_pkg::COEF_WIDTH-1:0];
        adm_filt_pkg::REG_TIME_STEP:  time_step  <= cfg_data[adm_filt_pkg::STEP_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      velocity     <= '0;
      displacement <= '0;
    end else begin
      case (cmd.acc_op)
        adm_filt_pkg::AO_DISP: displacement <= sat_add(displacement, prod);
        adm_filt_pkg::AO_VEL:  velocity     <= sat_add(velocity, prod);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_sat;
    case (cmd.acc_op)
      adm_filt_pkg::AO_LOAD: acc <= prod;
      adm_filt_pkg::AO_SUB:  acc <= sat_sub(acc, prod);
      default: begin
      end
    endcase
    if (cmd.load_input) begin
      ref_in <= ref_x;
      frc_in <= frc_x;
    end
    if (cmd.load_out) begin
      command <= cmd_x;
    end
  end

endmodule

`default_nettype wire

// ----- bench/admittance_filter_one_axis_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// admittance_filter_one_axis_tb
// Self-checking bench for the one-axis admittance filter. It runs directed
// extremes, then random ticks under many coefficient settings and idling
// patterns. Every returned command is checked against an in-bench
// mass-spring-damper Euler predictor.
// ----------------------------------------------------------------------------

module admittance_filter_one_axis_tb;

  localparam int IO_WIDTH = adm_filt_pkg::IO_WIDTH;
  localparam int COEF_WIDTH = adm_filt_pkg::COEF_WIDTH;
  localparam int STEP_WIDTH = adm_filt_pkg::STEP_WIDTH;
  localparam longint DMAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint DMIN = -DMAX - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic signed [IO_WIDTH-1:0] reference;
    logic signed [IO_WIDTH-1:0] ext_force;
  } tick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IO_WIDTH-1:0] reference = '0;
  logic signed [IO_WIDTH-1:0] ext_force = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [IO_WIDTH-1:0] command;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  adm_filt_pkg::cfg_reg_t cfg_index = adm_filt_pkg::REG_INV_MASS;
  logic [IO_WIDTH-1:0] cfg_data = '0;

  admittance_filter_one_axis u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .reference(reference),
    .ext_force(ext_force),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .command(command),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [COEF_WIDTH-1:0] mass_inv_q = '0;
  logic [COEF_WIDTH-1:0] damp_q = '0;
  logic [COEF_WIDTH-1:0] stiff_q = '0;
  logic [STEP_WIDTH-1:0] step_q = '0;
  longint axis_vel = 0;
  longint axis_disp = 0;

  tick_t pending_ticks[$];
  logic signed [IO_WIDTH-1:0] due_commands[$];
  tick_t next_tick;
  logic signed [IO_WIDTH-1:0] want_cmd;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_kick = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int ticks_sent = 0;
  int cmds_seen = 0;
  int errors = 0;
  int reg_writes = 0;

  function automatic longint clamp32(longint v);
    if (v > DMAX) return DMAX;
    if (v < DMIN) return DMIN;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> 16);
  endfunction

  function logic signed [IO_WIDTH-1:0] advance_axis(logic signed [IO_WIDTH-1:0] ref_pos,
                                                    logic signed [IO_WIDTH-1:0] force_in);
    longint acc;
    longint old_vel;
    longint cmd;
    old_vel = axis_vel;
    acc = qmul(longint'(force_in), longint'(mass_inv_q));
    acc = clamp32(acc - qmul(longint'(damp_q), axis_vel));
    acc = clamp32(acc - qmul(longint'(stiff_q), axis_disp));
    axis_disp = clamp32(axis_disp + qmul(old_vel, longint'(step_q)));
    axis_vel = clamp32(axis_vel + qmul(acc, longint'(step_q)));
    cmd = clamp32(longint'(ref_pos) - axis_disp);
    return cmd[IO_WIDTH-1:0];
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_commands.push_back(advance_axis(reference, ext_force));
        ticks_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_tick = pending_ticks.pop_front();
          in_valid <= 1'b1;
          reference <= next_tick.reference;
          ext_force <= next_tick.ext_force;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        cmds_seen++;
        if (due_commands.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected command %0d", command);
        end else begin
          want_cmd = due_commands.pop_front();
          if (command !== want_cmd) begin
            errors++;
            if (errors <= 10) begin
              $display("command mismatch on result %0d: expected %0d, got %0d",
                       cmds_seen, want_cmd, command);
            end
          end
        end
      end
      if (hold_kick) begin
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("admittance_filter_one_axis_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(adm_filt_pkg::cfg_reg_t idx, logic [IO_WIDTH-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      adm_filt_pkg::REG_INV_MASS:   mass_inv_q = data[COEF_WIDTH-1:0];
      adm_filt_pkg::REG_DAMP_COEF:  damp_q = data[COEF_WIDTH-1:0];
      adm_filt_pkg::REG_STIFF_COEF: stiff_q = data[COEF_WIDTH-1:0];
      adm_filt_pkg::REG_TIME_STEP:  step_q = data[STEP_WIDTH-1:0];
      default: ;
    endcase
    axis_vel = 0;
    axis_disp = 0;
    reg_writes++;
  endtask

  task automatic write_all(logic [IO_WIDTH-1:0] inv, logic [IO_WIDTH-1:0] damp,
                           logic [IO_WIDTH-1:0] stiff, logic [IO_WIDTH-1:0] step);
    write_reg(adm_filt_pkg::REG_INV_MASS, inv);
    write_reg(adm_filt_pkg::REG_DAMP_COEF, damp);
    write_reg(adm_filt_pkg::REG_STIFF_COEF, stiff);
    write_reg(adm_filt_pkg::REG_TIME_STEP, step);
  endtask

  task automatic queue_tick(logic [IO_WIDTH-1:0] ref_pos, logic [IO_WIDTH-1:0] force_in);
    tick_t t;
    t.reference = ref_pos;
    t.ext_force = force_in;
    pending_ticks.push_back(t);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_ticks.size() != 0 || due_commands.size() != 0 || in_valid);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  function automatic logic [IO_WIDTH-1:0] rand_coef();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(32'h0020_0000);
    endcase
  endfunction

  function automatic logic [IO_WIDTH-1:0] rand_step();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'h0001_FFFF;
      2: return 32'h0001_0000;
      3: return $urandom();
      default: return $urandom_range(32'd3277, 32'd1);
    endcase
  endfunction

  function automatic logic [IO_WIDTH-1:0] pick_extreme();
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic queue_random(int count);
    logic [IO_WIDTH-1:0] r;
    logic [IO_WIDTH-1:0] f;
    logic [IO_WIDTH-1:0] base_force;
    base_force = $urandom_range(32'h0064_0000) - 32'h0032_0000;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: begin
          r = $urandom();
          f = $urandom();
        end
        1: begin
          r = pick_extreme();
          f = pick_extreme();
        end
        default: begin
          if ($urandom_range(7) == 0) base_force = $urandom_range(32'h0064_0000) - 32'h0032_0000;
          r = $urandom_range(32'h0014_0000) - 32'h000A_0000;
          f = base_force + $urandom_range(32'h0000_4000) - 32'h0000_2000;
        end
      endcase
      queue_tick(r, f);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Unit mass with a one-second step, driven by the field extremes.
    write_all(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0001_0000);
    @(negedge clk);
    queue_tick(32'h0000_0000, 32'h0001_0000);
    queue_tick(32'h0001_0000, 32'h0001_0000);
    queue_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_tick(32'h8000_0000, 32'h8000_0000);
    queue_tick(32'h8000_0000, 32'h7FFF_FFFF);
    queue_tick(32'h7FFF_FFFF, 32'h8000_0000);
    queue_tick(32'h0000_0000, 32'h0000_0000);
    queue_tick(32'h0000_0000, 32'hFFFF_FFFF);
    wait_drained();

    // All-zero coefficients leave the state untouched.
    write_all('0, '0, '0, '0);
    @(negedge clk);
    queue_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_tick(32'h8000_0000, 32'h8000_0000);
    queue_tick(32'h1234_5678, 32'hFFFF_FFFB);
    wait_drained();

    // Oversized writes are masked, and the step exceeds one second.
    write_all(32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_tick(32'h0000_0000, 32'h0001_0000);
    queue_tick(32'h0000_0000, 32'hFFFF_0000);
    queue_tick(32'h0000_0001, 32'h0000_0001);
    queue_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_tick(32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();

    // Tiny coefficients expose the floor rounding of negative products.
    write_all(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    @(negedge clk);
    queue_tick(32'h0000_0000, 32'hFFFF_FFFF);
    queue_tick(32'h0000_0000, 32'h0000_0001);
    queue_tick(32'h0000_0000, 32'h8000_0001);
    queue_tick(32'h7FFF_0000, 32'h8000_0000);
    wait_drained();
    write_reg(adm_filt_pkg::REG_TIME_STEP, 32'h0000_0001);
    @(negedge clk);
    queue_tick(32'h0000_0000, 32'h8000_0000);
    queue_tick(32'h0000_0000, 32'h8000_0000);
    wait_drained();

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: set_idle(0, 0);
        1: set_idle(88, 0);
        2: set_idle(0, 88);
        default: set_idle(6, 6);
      endcase
      if (p == 1) begin
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_FFFF);
      end else if (p == 2) begin
        write_all('0, '0, '0, rand_step());
      end else if (p % 3 == 0) begin
        write_all(32'h0001_0000, $urandom_range(32'h0014_0000), $urandom_range(32'h0064_0000),
                  $urandom_range(32'd3277, 32'd1));
      end else begin
        write_all(rand_coef(), rand_coef(), rand_coef(), rand_step());
      end
      @(negedge clk);
      queue_random(70);
      if (p == 0) begin
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      wait_drained();
      write_reg(adm_filt_pkg::cfg_reg_t'($urandom_range(3)),
                ($urandom_range(1) == 0) ? rand_coef() : rand_step());
      @(negedge clk);
      queue_random(70);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    errors += due_commands.size();
    $display("Sent %0d ticks and checked %0d commands across %0d register writes,",
             ticks_sent, cmds_seen, reg_writes);
    $display("with idle and stalled phases, a long output hold, and %0d failures.", errors);
    if (errors == 0) begin
      $display("admittance_filter_one_axis_tb OK");
    end else begin
      $display("admittance_filter_one_axis_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/adm_filt_pkg.sv
rtl/core/adm_filt_ctrl.sv
rtl/core/adm_filt_dp.sv
rtl/core/admittance_filter_one_axis.sv
bench/admittance_filter_one_axis_tb.sv
